// ----- sv/ifd_pkg.sv -----
// Shared constants, codes and types for the IPv4 forwarding decision block.
`timescale 1ns / 1ps

package ifd_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int PORT_COUNT    = 4;
  localparam int ADDR_PORTS    = 4;
  localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ROUTE_ENTRIES + 1);
  localparam int ROUTE_W       = 32 + 32 + 2;

  localparam logic [15:0] MIN_LOCAL_LENGTH  = 16'd21;
  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [1:0] KIND_ARP_REQUEST = 2'd0;
  localparam logic [1:0] KIND_ARP_REPLY   = 2'd1;
  localparam logic [1:0] KIND_IPV4        = 2'd2;

  typedef enum logic [3:0] {
    ACT_DROP          = 4'd0,
    ACT_ARP_REPLY     = 4'd1,
    ACT_ARP_LEARN     = 4'd2,
    ACT_FORWARD       = 4'd3,
    ACT_ECHO_REPLY    = 4'd4,
    ACT_TIME_EXCEEDED = 4'd5,
    ACT_NET_UNREACH   = 4'd6,
    ACT_PORT_UNREACH  = 4'd7,
    ACT_WRITE_DONE    = 4'd8
  } action_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] best;
    logic [1:0]       port;
  } srch_status_t;

endpackage

// ----- sv/ifd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ifd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ifd_search.sv -----
// Route table storage and the sequential longest-prefix search over it.
`timescale 1ns / 1ps

module ifd_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [ifd_pkg::IDX_W-1:0] wr_idx,
  input  logic [31:0]               wr_prefix,
  input  logic [31:0]               wr_mask,
  input  logic [1:0]                wr_port,
  input  logic                      wr_valid,
  input  logic                      start,
  input  logic [31:0]               key,
  output ifd_pkg::srch_status_t     status
);
  import ifd_pkg::*;

  logic [ROUTE_ENTRIES-1:0] valid_bits;
  logic [ROUTE_W-1:0]       rd_word;
  logic [31:0]              rd_prefix;
  logic [31:0]              rd_mask;
  logic [1:0]               rd_port;
  logic                     busy;
  logic [CNT_W-1:0]         issue_cnt;
  logic                     pend;
  logic [IDX_W-1:0]         pend_idx;
  logic                     found;
  logic [IDX_W-1:0]         best;
  logic [31:0]              lead_mask;
  logic [1:0]               best_port;
  logic [31:0]              key_q;
  logic                     issuing;
  logic                     hit;
  logic                     take;
  logic                     done;

  ifd_ram #(
    .WIDTH(ROUTE_W),
    .DEPTH(ROUTE_ENTRIES)
  ) u_route_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata({wr_prefix, wr_mask, wr_port}),
    .raddr(issue_cnt[IDX_W-1:0]),
    .rdata(rd_word)
  );

  assign rd_prefix = rd_word[ROUTE_W-1 -: 32];
  assign rd_mask   = rd_word[33:2];
  assign rd_port   = rd_word[1:0];

  assign issuing = busy && (issue_cnt < CNT_W'(ROUTE_ENTRIES));
  assign hit     = pend && valid_bits[pend_idx] && ((key_q & rd_mask) == (rd_prefix & rd_mask));
  assign take    = hit && (!found || (rd_mask > lead_mask));
  assign done    = busy && !issuing && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_idx] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
      issue_cnt <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      pend      <= 1'b0;
      found     <= 1'b0;
      issue_cnt <= '0;
    end else if (busy) begin
      pend <= issuing;
      if (issuing) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    pend_idx <= issue_cnt[IDX_W-1:0];
    if (take) begin
      best      <= pend_idx;
      lead_mask <= rd_mask;
      best_port <= rd_port;
    end
  end

  assign status = '{done: done, found: found, best: best, port: best_port};

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= CNT_W'(ROUTE_ENTRIES))
    else $error("Search issue counter ran past the table.");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend |-> busy)
    else $error("A read is pending outside a search.");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("Search started while another is running.");

endmodule

// ----- sv/ipv4_forward_decision_lpm.sv -----
// Top level of the IPv4 forwarding decision block with longest-prefix route lookup.
//
//  Channel | Signals                                 | Dir | Word
//  in      | in_valid, in_ready, cmd..total_length   | in  | route write or parsed packet
//  out     | out_valid, out_ready, action..route_hit | out | one decision per input word
//  cfg     | cfg_we, cfg_index, cfg_data             | in  | port address write
//
//  Route writes and locally decided packets pass from acceptance through S_DONE to the registered output.
//  A forwarded packet with TTL above one walks the route memory one entry per cycle,
//  a pace set by the single read port.
//  One word is processed at a time; a held output word holds the next word in S_DONE, and in_ready stays low.
//  Reset clears the port addresses and all route valid bits.
`timescale 1ns / 1ps

module ipv4_forward_decision_lpm (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [3:0]  entry_index,
  input  logic [31:0] address,
  input  logic [31:0] mask,
  input  logic [1:0]  port,
  input  logic        entry_valid,
  input  logic [1:0]  kind,
  input  logic [7:0]  ttl,
  input  logic [7:0]  protocol,
  input  logic [7:0]  icmp_msg,
  input  logic        header_ok,
  input  logic [15:0] total_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  action,
  output logic [1:0]  egress_port,
  output logic [7:0]  new_ttl,
  output logic [3:0]  route_hit
);
  import ifd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_t;

  state_t       state;
  state_t       state_next;
  logic [31:0]  port_addr [ADDR_PORTS];
  logic         accept;
  logic         wr_en;
  logic         start;
  logic         port_ok;
  logic         is_local;
  logic         needs_search;
  action_t      dec_action;
  action_t      res_action;
  logic [1:0]   res_port;
  logic [7:0]   res_ttl;
  logic [3:0]   res_hit;
  logic [1:0]   pkt_port;
  logic [7:0]   pkt_ttl;
  logic         out_free;
  srch_status_t srch;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (cmd == CMD_WRITE) && (int'(entry_index) < ROUTE_ENTRIES);
  assign start    = accept && (cmd == CMD_PACKET) && needs_search;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ADDR_PORTS; i++) begin
        port_addr[i] <= '0;
      end
    end else if (cfg_we) begin
      port_addr[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    is_local = 1'b0;
    for (int i = 0; i < ADDR_PORTS; i++) begin
      if ((i < PORT_COUNT) && (port_addr[i] == address)) begin
        is_local = 1'b1;
      end
    end
  end

  always_comb begin
    port_ok      = (int'(port) < PORT_COUNT);
    needs_search = 1'b0;
    dec_action   = ACT_DROP;
    if (!port_ok) begin
      dec_action = ACT_DROP;
    end else begin
      unique case (kind) inside
        KIND_ARP_REQUEST, KIND_ARP_REPLY: begin
          if (address != port_addr[port]) begin
            dec_action = ACT_DROP;
          end else if (kind == KIND_ARP_REQUEST) begin
            dec_action = ACT_ARP_REPLY;
          end else begin
            dec_action = ACT_ARP_LEARN;
          end
        end
        KIND_IPV4: begin
          if (is_local) begin
            if (!header_ok || (total_length < MIN_LOCAL_LENGTH)) begin
              dec_action = ACT_DROP;
            end else if (protocol != PROTO_ICMP) begin
              dec_action = ACT_PORT_UNREACH;
            end else if (icmp_msg == ICMP_ECHO_REQUEST) begin
              dec_action = ACT_ECHO_REPLY;
            end else begin
              dec_action = ACT_DROP;
            end
          end else if (ttl <= 8'd1) begin
            dec_action = ACT_TIME_EXCEEDED;
          end else begin
            needs_search = 1'b1;
          end
        end
        default: dec_action = ACT_DROP;
      endcase
    end
  end

  ifd_search u_search (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_idx   (IDX_W'(entry_index)),
    .wr_prefix(address),
    .wr_mask  (mask),
    .wr_port  (port),
    .wr_valid (entry_valid),
    .start    (start),
    .key      (address),
    .status   (srch)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = start ? S_SEARCH : S_DONE;
        end
      end
      S_SEARCH: begin
        if (srch.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pkt_port <= port;
      pkt_ttl  <= ttl;
      res_ttl  <= '0;
      res_hit  <= '0;
      if (cmd == CMD_WRITE) begin
        res_action <= ACT_WRITE_DONE;
        res_port   <= '0;
      end else begin
        res_action <= dec_action;
        res_port   <= port;
      end
    end else if ((state == S_SEARCH) && srch.done) begin
      if (srch.found) begin
        res_action <= ACT_FORWARD;
        res_port   <= srch.port;
        res_ttl    <= pkt_ttl - 8'd1;
        res_hit    <= 4'(srch.best);
      end else begin
        res_action <= ACT_NET_UNREACH;
        res_port   <= pkt_port;
        res_ttl    <= '0;
        res_hit    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      action      <= res_action;
      egress_port <= res_port;
      new_ttl     <= res_ttl;
      route_hit   <= res_hit;
    end
  end

  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    srch.done |-> (state == S_SEARCH))
    else $error("Search finished outside the search state.");

  a_forward_ttl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == ACT_FORWARD)) |-> (new_ttl != 8'd0))
    else $error("Forwarded word carries a zero TTL.");

  a_local_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action != ACT_FORWARD)) |-> ((new_ttl == 8'd0) && (route_hit == 4'd0)))
    else $error("Non-forward word carries TTL or route index.");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("Control state lost its one-hot code.");

endmodule
